FILE: sv/scoredist_distance_top_defines.svh
// Assertion macros shared by the scoredist distance RTL.
`ifndef SCOREDIST_DISTANCE_TOP_DEFINES_SVH
`define SCOREDIST_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scoredist_distance: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoredist_distance: assertion failed");

`endif

FILE: sv/sd_pkg.sv
// Package: types, constants and substitution table for the scoredist distance block.
`default_nettype none
package sd_pkg;

  localparam int CODE_W   = 5;
  localparam int NCODES   = 20;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 17;
  localparam int EXP_W    = 18;
  localparam int CAL_W    = 17;
  localparam int DIST_W   = 21;
  localparam int CFG_W    = 18;
  localparam int WIDE_W   = 43;
  localparam int PROD_W   = 53;
  localparam int M_W      = 31;
  localparam int E_W      = 6;
  localparam int FRAC_W   = 30;
  localparam int LOG_W    = E_W + FRAC_W;
  localparam int DQ_W     = 23;
  localparam int DM_W     = 24;
  localparam int SQ_CNT_W = 5;

  localparam logic [CNT_W-1:0]  COUNT_CAP     = 17'd65536;
  localparam logic [EXP_W-1:0]  EXP_RESET     = 18'h3_7AA7;  // -34137
  localparam logic [CAL_W-1:0]  CAL_RESET     = 17'd84365;   // 1.2873 in Q16
  localparam logic [23:0]       LN2_Q24       = 24'd11629080;
  localparam logic [DM_W-1:0]   DIST_POS_MAX  = 24'd1048575;
  localparam logic [DM_W-1:0]   DIST_NEG_MAX  = 24'd1048576;
  localparam logic [E_W-1:0]    E_START       = 6'd30;
  localparam logic [SQ_CNT_W-1:0] SQ_LAST_IDX = 5'd29;

  typedef enum logic [0:0] {
    CFG_EXPECTED = 1'b0,
    CFG_CALIB    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] letter_a;
    logic [CODE_W-1:0] letter_b;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     ratio_low;
    logic                     upper_zero;
  } out_item_t;

  typedef struct packed {
    logic acc_en;
    logic rnd_en;
    logic norm_en;
    logic cmp_en;
    logic log_load;
    logic log_load_um;
    logic log_norm;
    logic log_sq;
    logic log_store;
    logic log_store_u;
    logic ml_en;
    logic mh_en;
    logic dq_en;
    logic dm_en;
    logic out_load;
  } sd_cmd_t;

  typedef struct packed {
    logic upper_zero;
    logic ratio_low;
    logic norm_done;
  } sd_stat_t;

  localparam logic signed [4:0] BLOSUM62 [0:399] = '{
     4, 0,-2,-1,-2, 0,-2,-1,-1,-1,-1,-2,-1,-1,-1, 1, 0, 0,-3,-2,
     0, 9,-3,-4,-2,-3,-3,-1,-3,-1,-1,-3,-3,-3,-3,-1,-1,-1,-2,-2,
    -2,-3, 6, 2,-3,-1,-1,-3,-1,-4,-3, 1,-1, 0,-2, 0,-1,-3,-4,-3,
    -1,-4, 2, 5,-3,-2, 0,-3, 1,-3,-2, 0,-1, 2, 0, 0,-1,-2,-3,-2,
    -2,-2,-3,-3, 6,-3,-1, 0,-3, 0, 0,-3,-4,-3,-3,-2,-2,-1, 1, 3,
     0,-3,-1,-2,-3, 6,-2,-4,-2,-4,-3, 0,-2,-2,-2, 0,-2,-3,-2,-3,
    -2,-3,-1, 0,-1,-2, 8,-3,-1,-3,-2, 1,-2, 0, 0,-1,-2,-3,-2, 2,
    -1,-1,-3,-3, 0,-4,-3, 4,-3, 2, 1,-3,-3,-3,-3,-2,-1, 3,-3,-1,
    -1,-3,-1, 1,-3,-2,-1,-3, 5,-2,-1, 0,-1, 1, 2, 0,-1,-2,-3,-2,
    -1,-1,-4,-3, 0,-4,-3, 2,-2, 4, 2,-3,-3,-2,-2,-2,-1, 1,-2,-1,
    -1,-1,-3,-2, 0,-3,-2, 1,-1, 2, 5,-2,-2, 0,-1,-1,-1, 1,-1,-1,
    -2,-3, 1, 0,-3, 0, 1,-3, 0,-3,-2, 6,-2, 0, 0, 1, 0,-3,-4,-2,
    -1,-3,-1,-1,-4,-2,-2,-3,-1,-3,-2,-2, 7,-1,-2,-1,-1,-2,-4,-3,
    -1,-3, 0, 2,-3,-2, 0,-3, 1,-2, 0, 0,-1, 5, 1, 0,-1,-2,-2,-1,
    -1,-3,-2, 0,-3,-2, 0,-3, 2,-2,-1, 0,-2, 1, 5,-1,-1,-3,-3,-2,
     1,-1, 0, 0,-2, 0,-1,-2, 0,-2,-1, 1,-1, 0,-1, 4, 1,-2,-3,-2,
     0,-1,-1,-1,-2,-2,-2,-1,-1,-1,-1, 0,-1,-1,-1, 1, 5, 0,-2,-2,
     0,-1,-3,-2,-1,-3,-3, 3,-2, 1, 1,-3,-2,-2,-3,-2, 0, 4,-3,-1,
    -3,-2,-4,-3, 1,-2,-2,-3,-3,-2,-1,-4,-4,-2,-3,-3,-2,-3,11, 2,
    -2,-2,-3,-2, 3,-3, 2,-1,-2,-1,-1,-2,-3,-1,-2,-2,-2,-1, 2, 7
  };

  // score of a residue pair; zero for codes outside the table
  function automatic logic signed [4:0] blosum(input logic [CODE_W-1:0] a,
                                               input logic [CODE_W-1:0] b);
    logic [9:0] idx;
    idx = 10'(a) * 10'd20 + 10'(b);
    if (a < CODE_W'(NCODES) && b < CODE_W'(NCODES)) begin
      return BLOSUM62[idx[8:0]];
    end
    return 5'sd0;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sd_ctrl.sv
// Controller: sequences accumulation, scoring, serial log2 and output load.
`default_nettype none
module sd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire sd_pkg::sd_stat_t stat,
  output sd_pkg::sd_cmd_t    cmd
);
  import sd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RND, S_NORM, S_CMP, S_DEC, S_LNRM, S_LSQ, S_LST,
    S_ML, S_MH, S_DQ, S_DM, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [SQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 pass_r, pass_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fire      = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.acc_en = fire;
        if (fire && in_last) state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = S_NORM;
      end
      S_NORM: begin
        cmd.norm_en = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        if (stat.upper_zero || stat.ratio_low) begin
          state_nxt = S_FIN;
        end else begin
          cmd.log_load = 1'b1;
          pass_nxt     = 1'b0;
          state_nxt    = S_LNRM;
        end
      end
      S_LNRM: begin
        if (stat.norm_done) begin
          cnt_nxt   = SQ_LAST_IDX;
          state_nxt = S_LSQ;
        end else begin
          cmd.log_norm = 1'b1;
        end
      end
      S_LSQ: begin
        cmd.log_sq = 1'b1;
        if (cnt_r == '0) state_nxt = S_LST;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_LST: begin
        cmd.log_store   = 1'b1;
        cmd.log_store_u = pass_r;
        if (!pass_r) begin
          cmd.log_load    = 1'b1;
          cmd.log_load_um = 1'b1;
          pass_nxt        = 1'b1;
          state_nxt       = S_LNRM;
        end else begin
          state_nxt = S_ML;
        end
      end
      S_ML: begin
        cmd.ml_en = 1'b1;
        state_nxt = S_MH;
      end
      S_MH: begin
        cmd.mh_en = 1'b1;
        state_nxt = S_DQ;
      end
      S_DQ: begin
        cmd.dq_en = 1'b1;
        state_nxt = S_DM;
      end
      S_DM: begin
        cmd.dm_en = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sd_dpath.sv
// Datapath: accumulators, config registers, score math, log2 unit, result register.
`default_nettype none
module sd_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sd_pkg::in_item_t  in_data,
  input  wire logic              cfg_we,
  input  wire sd_pkg::cfg_idx_t  cfg_addr,
  input  wire logic [sd_pkg::CFG_W-1:0] cfg_wdata,
  input  wire sd_pkg::sd_cmd_t   cmd,
  output sd_pkg::sd_stat_t       stat,
  output sd_pkg::out_item_t      out_data
);
  import sd_pkg::*;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [4:0] d);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-4){d[4]}}, d};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  logic signed [EXP_W-1:0]  exp_r;
  logic        [CAL_W-1:0]  cal_r;
  logic signed [SUM_W-1:0]  pair_sum_r, self_a_r, self_b_r;
  logic        [CNT_W-1:0]  count_r;
  logic signed [36:0]       rnd_r;
  logic signed [WIDE_W-1:0] n2_r, un2_r;
  logic signed [PROD_W-1:0] k_r;
  logic        [WIDE_W-1:0] lm_r;
  logic        [E_W-1:0]    le_r;
  logic        [FRAC_W-1:0] lf_r;
  logic        [LOG_W-1:0]  ln_r, lu_r;
  logic                     neg_r;
  logic        [41:0]       pl_r, ph_r;
  logic        [DQ_W-1:0]   dq_r;
  logic        [DM_W-1:0]   dm_r;
  out_item_t                out_r;

  logic                     va, vb;
  logic signed [35:0]       rnd_p;
  logic signed [SUM_W:0]    self_tot;
  logic signed [PROD_W-1:0] n2x, un2x, k_nxt;
  logic        [WIDE_W-1:0] n2_abs, un2_abs;
  logic        [61:0]       sq_p;
  logic        [31:0]       sq_q;
  logic        [LOG_W-1:0]  mag;
  logic        [60:0]       dq_sum;
  logic        [39:0]       dm_p;
  logic        [DM_W-1:0]   dm_sat;
  out_item_t                res;

  assign va = in_data.letter_a < CODE_W'(NCODES);
  assign vb = in_data.letter_b < CODE_W'(NCODES);

  assign rnd_p    = $signed({1'b0, count_r}) * exp_r;
  assign self_tot = {self_a_r[SUM_W-1], self_a_r} + {self_b_r[SUM_W-1], self_b_r};
  assign n2x      = {{(PROD_W-WIDE_W){n2_r[WIDE_W-1]}}, n2_r};
  assign un2x     = {{(PROD_W-WIDE_W){un2_r[WIDE_W-1]}}, un2_r};
  // 1000 = 1024 - 16 - 8
  assign k_nxt    = (n2x <<< 10) - (n2x <<< 4) - (n2x <<< 3);
  assign n2_abs   = n2_r[WIDE_W-1] ? WIDE_W'(-n2_r) : WIDE_W'(n2_r);
  assign un2_abs  = un2_r[WIDE_W-1] ? WIDE_W'(-un2_r) : WIDE_W'(un2_r);

  assign stat.upper_zero = (un2_r == '0);
  assign stat.ratio_low  = (un2_r > 0 && k_r < un2x) || (un2_r < 0 && k_r > un2x);
  assign stat.norm_done  = (lm_r[WIDE_W-1:M_W] == '0) && lm_r[M_W-1];

  assign sq_p   = lm_r[M_W-1:0] * lm_r[M_W-1:0];
  assign sq_q   = sq_p[61:30];
  // both logs are stable once stored
  assign mag    = (lu_r < ln_r) ? (ln_r - lu_r) : (lu_r - ln_r);
  assign dq_sum = {1'b0, ph_r, 18'd0} + {19'd0, pl_r} + (61'd1 << 37);
  assign dm_p   = dq_r * cal_r;

  always_comb begin
    res    = '0;
    dm_sat = '0;
    if (un2_r == '0) begin
      res.upper_zero = 1'b1;
    end else if (stat.ratio_low) begin
      res.ratio_low = 1'b1;
      res.distance  = DIST_W'({cal_r, 1'b0}) + DIST_W'(cal_r);
    end else if (neg_r) begin
      dm_sat       = (dm_r > DIST_NEG_MAX) ? DIST_NEG_MAX : dm_r;
      res.distance = DIST_W'(-dm_sat);
    end else begin
      dm_sat       = (dm_r > DIST_POS_MAX) ? DIST_POS_MAX : dm_r;
      res.distance = DIST_W'(dm_sat);
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r      <= EXP_RESET;
      cal_r      <= CAL_RESET;
      pair_sum_r <= '0;
      self_a_r   <= '0;
      self_b_r   <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_EXPECTED: exp_r <= cfg_wdata[EXP_W-1:0];
          CFG_CALIB:    cal_r <= cfg_wdata[CAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.acc_en) begin
        if (va) self_a_r <= sat_add(self_a_r, blosum(in_data.letter_a, in_data.letter_a));
        if (vb) self_b_r <= sat_add(self_b_r, blosum(in_data.letter_b, in_data.letter_b));
        if (va && vb) begin
          pair_sum_r <= sat_add(pair_sum_r, blosum(in_data.letter_a, in_data.letter_b));
          if (count_r < COUNT_CAP) count_r <= count_r + 1'b1;
        end
      end else if (cmd.norm_en) begin
        pair_sum_r <= '0;
        self_a_r   <= '0;
        self_b_r   <= '0;
        count_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) rnd_r <= {rnd_p, 1'b0};
    if (cmd.norm_en) begin
      n2_r  <= {{2{pair_sum_r[SUM_W-1]}}, pair_sum_r, 17'd0} - {{6{rnd_r[36]}}, rnd_r};
      un2_r <= {{2{self_tot[SUM_W]}}, self_tot, 16'd0} - {{6{rnd_r[36]}}, rnd_r};
    end
    if (cmd.cmp_en) k_r <= k_nxt;
    if (cmd.log_store) begin
      if (cmd.log_store_u) lu_r <= {le_r, lf_r};
      else ln_r <= {le_r, lf_r};
    end
    if (cmd.log_load) begin
      lm_r <= cmd.log_load_um ? un2_abs : n2_abs;
      le_r <= E_START;
      lf_r <= '0;
    end else if (cmd.log_norm) begin
      if (lm_r[WIDE_W-1:M_W] != '0) begin
        lm_r <= lm_r >> 1;
        le_r <= le_r + 1'b1;
      end else begin
        lm_r <= lm_r << 1;
        le_r <= le_r - 1'b1;
      end
    end else if (cmd.log_sq) begin
      lm_r <= sq_q[31] ? WIDE_W'(sq_q[31:1]) : WIDE_W'(sq_q[30:0]);
      lf_r <= {lf_r[FRAC_W-2:0], sq_q[31]};
    end
    if (cmd.ml_en) begin
      neg_r <= lu_r < ln_r;
      pl_r  <= mag[17:0] * LN2_Q24;
    end
    if (cmd.mh_en) ph_r <= mag[35:18] * LN2_Q24;
    if (cmd.dq_en) dq_r <= dq_sum[60:38];
    if (cmd.dm_en) dm_r <= DM_W'((dm_p + 40'd32768) >> 16);
    if (cmd.out_load) out_r <= res;
  end

endmodule
`default_nettype wire

FILE: sv/scoredist_distance_top.sv
// Top level: scoredist protein distance over one streamed pairwise alignment.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_item_t  (letter_a, letter_b, last)
//  out_    | output    | out_valid/out_ready| out_item_t (distance, ratio_low, upper_zero)
//  cfg_    | input     | cfg_we             | cfg_addr, cfg_wdata
//
// Columns without last are accepted back to back.
// The last column starts the result; in_ready stays low until it is loaded.
// The wait is set by the shared serial log2 unit (per score normalize shifts, a
// done check, 30 squarings and a store), run once for each of the two scores.
// Special-case results skip the log2 unit. The result register waits for out_ready;
// a new result stalls only while the previous one is still unread.
// Reset is synchronous, active low; control, sum and config registers return to their defaults.
`default_nettype none
`include "scoredist_distance_top_defines.svh"
module scoredist_distance_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire sd_pkg::in_item_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output sd_pkg::out_item_t             out_data,
  input  wire logic                     cfg_we,
  input  wire sd_pkg::cfg_idx_t         cfg_addr,
  input  wire logic [sd_pkg::CFG_W-1:0] cfg_wdata
);
  import sd_pkg::*;

  sd_cmd_t  cmd;
  sd_stat_t stat;

  // controller: column transfers, result sequencing, output valid
  sd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: sums, Q17 scores, log2 difference, calibration, result register
  sd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // the two special cases never flag together
  `SD_ASSERT_SAME(a_flags_excl, out_valid, !(out_data.ratio_low && out_data.upper_zero))
  // zero upper limit gives zero distance
  `SD_ASSERT_SAME(a_uz_zero, out_valid && out_data.upper_zero, out_data.distance == '0)
  // large distance is never negative
  `SD_ASSERT_SAME(a_rl_pos, out_valid && out_data.ratio_low, !out_data.distance[DIST_W-1])
  // a last-column transfer stops intake for the result computation
  `SD_ASSERT_NEXT(a_last_stall, in_valid && in_ready && in_data.last, !in_ready)

endmodule
`default_nettype wire
